// ===== rtl/cra_pkg.sv =====
package cra_pkg;

    // Store geometry: 16 translation tables of 256 codes, 256 glyphs of 16 rows.
    localparam int STORE_ADDR_W = 12;
    localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;

    typedef logic [STORE_ADDR_W-1:0] t_addr;
    typedef logic [7:0]              t_byte;
    typedef logic [1:0]              t_pen;

    // Request opcodes.
    localparam logic [1:0] OP_DRAW     = 2'd0;
    localparam logic [1:0] OP_WR_TRANS = 2'd1;
    localparam logic [1:0] OP_WR_GLYPH = 2'd2;

    // Pen indices.
    localparam t_pen PEN_BLACK     = 2'd0;
    localparam t_pen PEN_HIGHLIGHT = 2'd1;
    localparam t_pen PEN_NORMAL    = 2'd2;

    // Forced glyph patterns.
    localparam t_byte GLYPH_ON  = 8'hff;
    localparam t_byte GLYPH_OFF = 8'h00;

    // Bit positions in video_control and attribute.
    localparam int VC_REVERSE_BIT   = 1;
    localparam int ATTR_BOLD_BIT    = 4;
    localparam int ATTR_ULINE_BIT   = 3;
    localparam int ATTR_INVERT_BIT  = 2;
    localparam int ATTR_BLINK_BIT   = 1;
    localparam int ATTR_INVIS_BIT   = 0;

    // Per-cell information that travels with a draw request down the pipeline.
    typedef struct packed {
        logic       bold;
        logic       underline;
        logic       invert;
        logic       blink;
        logic       invisible;
        logic       ul_line;
        logic       blink_phase;
        logic       cursor;
        logic       dw;
        logic       half;
        logic [3:0] row;
    } t_cell;

endpackage

// ===== rtl/cra_ram.sv =====
module cra_ram
    import cra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_wr_en,
    input  t_addr i_wr_addr,
    input  t_byte i_wr_data,
    input  logic  i_rd_en,
    input  t_addr i_rd_addr,
    output t_byte o_rd_data
);

    t_byte r_mem [STORE_DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-before-write: a read at the same edge as a write sees the old byte.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/char_row_attribute_renderer.sv =====
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ------------------------------------------
// in        sink       i_in_valid / o_in_stall  opcode, table address/data, cell fields
// out       source     o_out_valid / i_out_stall pixel_bits, foreground_pen, background_pen
// cfg       sink       i_cfg_valid / o_cfg_ready video_control write data
//
// One request per cycle while the input is not stalled. A draw passes three register
// stages: translation read at the accepting edge, then glyph read, then attribute
// logic into the output register; a stall can hold it between stages. Loads write their
// store at the accepting edge and produce no result. Reset (synchronous, active low)
// clears stage valids, double-width state and video_control but not the stores. A
// stalled output holds its request; the input stalls only when every stage is full.
module char_row_attribute_renderer
    import cra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_table_address,
    input  logic [7:0]  i_table_data,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attribute,
    input  logic [3:0]  i_glyph_row,
    input  logic        i_double_width,
    input  logic        i_underline_line,
    input  logic        i_blink_phase,
    input  logic        i_cursor_here,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_bits,
    output logic [1:0]  o_foreground_pen,
    output logic [1:0]  o_background_pen,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    // Configuration and double-width state.
    logic [7:0] r_video_control;
    logic       r_second_half;
    logic [7:0] r_saved_code;
    logic [7:0] r_saved_attr;
    logic [2:0] r_saved_flags;

    // Pipeline stages.
    logic  r1_valid, r2_valid, r_out_valid;
    t_cell r1_cell, r2_cell;
    t_byte r_pixel_bits;
    t_pen  r_fg_pen, r_bg_pen;

    logic  adv1, adv2, adv3;
    logic  in_accept, acc_draw;
    logic  use_saved;
    logic [7:0] cur_code, cur_attr;
    logic       cur_ul, cur_blink, cur_cursor;
    logic [3:0] table_num;
    t_cell      in_cell;
    t_byte      trans_q, glyph_q;

    t_byte      n_glyph;
    logic [3:0] n_nibble;
    t_byte      n_pixel_bits;
    t_pen       n_fg_pen, n_bg_pen;

    // The config port is always ready; writes must only arrive while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    // Each stage moves when the stage after it is empty or moving too.
    assign adv3 = !r_out_valid || !i_out_stall;
    assign adv2 = !r2_valid || adv3;
    assign adv1 = !r1_valid || adv2;

    assign o_in_stall = !adv1;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign acc_draw   = in_accept && (i_opcode == OP_DRAW);

    // The second half of a double-width character replays what the first half saved.
    assign use_saved  = i_double_width && r_second_half;
    assign cur_code   = use_saved ? r_saved_code     : i_char_code;
    assign cur_attr   = use_saved ? r_saved_attr     : i_attribute;
    assign cur_ul     = use_saved ? r_saved_flags[0] : i_underline_line;
    assign cur_blink  = use_saved ? r_saved_flags[1] : i_blink_phase;
    assign cur_cursor = use_saved ? r_saved_flags[2] : i_cursor_here;

    // Table number is bits 0,4,3,2 of video_control, bit 0 most significant.
    assign table_num = {r_video_control[0], r_video_control[4],
                        r_video_control[3], r_video_control[2]};

    always_comb begin
        in_cell             = '0;
        in_cell.bold        = cur_attr[ATTR_BOLD_BIT];
        in_cell.underline   = cur_attr[ATTR_ULINE_BIT];
        in_cell.invert      = cur_attr[ATTR_INVERT_BIT];
        in_cell.blink       = cur_attr[ATTR_BLINK_BIT];
        in_cell.invisible   = cur_attr[ATTR_INVIS_BIT];
        in_cell.ul_line     = cur_ul;
        in_cell.blink_phase = cur_blink;
        in_cell.cursor      = cur_cursor;
        in_cell.dw          = i_double_width;
        in_cell.half        = r_second_half;
        in_cell.row         = i_glyph_row;
    end

    // Translation store: written by load requests, read as a draw is accepted.
    cra_ram u_trans (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && (i_opcode == OP_WR_TRANS)),
        .i_wr_addr (i_table_address),
        .i_wr_data (i_table_data),
        .i_rd_en   (acc_draw),
        .i_rd_addr ({table_num, cur_code}),
        .o_rd_data (trans_q)
    );

    // Glyph store: read when the draw leaves stage one. A glyph write accepted at
    // that same edge belongs to a later request, so the read returning the old byte
    // keeps request order.
    cra_ram u_glyph (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && (i_opcode == OP_WR_GLYPH)),
        .i_wr_addr (i_table_address),
        .i_wr_data (i_table_data),
        .i_rd_en   (r1_valid && adv2),
        .i_rd_addr ({trans_q, r1_cell.row}),
        .o_rd_data (glyph_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_control <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_video_control <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_half <= 1'b0;
            r_saved_code  <= '0;
            r_saved_attr  <= '0;
            r_saved_flags <= '0;
        end else if (acc_draw && i_double_width) begin
            r_second_half <= !r_second_half;
            if (!r_second_half) begin
                r_saved_code  <= i_char_code;
                r_saved_attr  <= i_attribute;
                r_saved_flags <= {i_cursor_here, i_blink_phase, i_underline_line};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r1_valid <= acc_draw;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
            if (adv3) begin
                r_out_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_draw) begin
            r1_cell <= in_cell;
        end
        if (r1_valid && adv2) begin
            r2_cell <= r1_cell;
        end
        if (r2_valid && adv3) begin
            r_pixel_bits <= n_pixel_bits;
            r_fg_pen     <= n_fg_pen;
            r_bg_pen     <= n_bg_pen;
        end
    end

    // Attribute logic, applied in this order: underline, blink, invisible, invert, cursor.
    always_comb begin
        n_glyph = glyph_q;
        if (r2_cell.ul_line && r2_cell.underline) begin
            n_glyph = GLYPH_ON;
        end
        if (r2_cell.blink_phase && r2_cell.blink) begin
            n_glyph = GLYPH_OFF;
        end
        if (r2_cell.invisible) begin
            n_glyph = GLYPH_OFF;
        end
        if (r2_cell.invert) begin
            n_glyph = ~n_glyph;
        end
        if (r2_cell.cursor) begin
            n_glyph = ~n_glyph;
        end

        // A double-width half stretches one nibble across the eight pixels.
        n_nibble = r2_cell.half ? n_glyph[3:0] : n_glyph[7:4];
        if (r2_cell.dw) begin
            n_pixel_bits = {n_nibble[3], n_nibble[3], n_nibble[2], n_nibble[2],
                            n_nibble[1], n_nibble[1], n_nibble[0], n_nibble[0]};
        end else begin
            n_pixel_bits = n_glyph;
        end

        // Reverse video swaps the two pens.
        if (r_video_control[VC_REVERSE_BIT]) begin
            n_fg_pen = PEN_BLACK;
            n_bg_pen = r2_cell.bold ? PEN_HIGHLIGHT : PEN_NORMAL;
        end else begin
            n_fg_pen = r2_cell.bold ? PEN_HIGHLIGHT : PEN_NORMAL;
            n_bg_pen = PEN_BLACK;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_bits     = r_pixel_bits;
    assign o_foreground_pen = r_fg_pen;
    assign o_background_pen = r_bg_pen;

    // Load requests never enter the draw pipeline.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_opcode != OP_DRAW)) |=> !r1_valid)
        else $error("load request entered the draw pipeline");

    // The half flag flips on every accepted double-width draw.
    a_half_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_draw && i_double_width) |=> (r_second_half != $past(r_second_half)))
        else $error("second half flag did not toggle");

    // A draw held in stage one blocks the input, so no glyph write can pass it.
    a_stage1_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !adv2) |-> o_in_stall)
        else $error("input accepted while stage one is blocked");

    // A result waiting on the output keeps the request behind it in stage two.
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r2_valid) |=> r2_valid)
        else $error("stage two lost a request under output stall");

endmodule
